// ===== rtl/sdi_pkg.sv =====
// Package for the SD card SPI-mode sequencer: phase codes, command opcodes,
// status codes and small helper functions. No dependencies.
package sdi_pkg;

   typedef enum logic [4:0] {
      PH_IDLE, PH_SPIN_PRE, PH_SPIN_SDHC, PH_SPIN_V1, PH_SPIN_V2, PH_SPIN_V2R,
      PH_CMD, PH_RESP, PH_R7, PH_TAIL8, PH_V1PRE, PH_TAIL1, PH_TAIL55, PH_TAIL41,
      PH_OCR, PH_TAIL16, PH_RDPRE, PH_TOKEN, PH_DATA, PH_CRC
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_RESET_FAIL = 2'd1, ST_READ_REJECT = 2'd2, ST_TOKEN_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_INIT = 2'd0, CMD_READ = 2'd1, CMD_BYTE = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_SLOW_DIV, CSR_FAST_DIV, CSR_IDLE_FILL, CSR_RESP_POLL,
      CSR_RESET_ATT, CSR_V1_ATT, CSR_V2_ATT, CSR_TOKEN_POLL
   } csr_type;

   // Opcodes: bits [7:0] command byte, bits [23:16] CRC byte.
   localparam logic [23:0] OP_CMD0   = 24'h950040;
   localparam logic [23:0] OP_CMD1   = 24'hff0041;
   localparam logic [23:0] OP_CMD17  = 24'hff0051;
   localparam logic [23:0] OP_CMD8   = 24'h870048;
   localparam logic [23:0] OP_CMD16  = 24'hFF0050;
   localparam logic [23:0] OP_ACMD41 = 24'h870069;
   localparam logic [23:0] OP_CMD55  = 24'hff0077;
   localparam logic [23:0] OP_CMD58  = 24'hff007A;

   localparam logic [5:0] IDX_CMD0  = 6'd0;
   localparam logic [5:0] IDX_CMD1  = 6'd1;
   localparam logic [5:0] IDX_CMD8  = 6'd8;
   localparam logic [5:0] IDX_CMD16 = 6'd16;
   localparam logic [5:0] IDX_CMD17 = 6'd17;
   localparam logic [5:0] IDX_CMD41 = 6'd41;
   localparam logic [5:0] IDX_CMD55 = 6'd55;
   localparam logic [5:0] IDX_CMD58 = 6'd58;

   localparam logic [31:0] ARG_CMD8   = 32'h000001AA;
   localparam logic [31:0] ARG_ACMD41 = 32'h40000000;
   localparam logic [7:0]  TOKEN_START = 8'hFE;
   localparam logic [7:0]  ECHO_PATTERN = 8'hAA;
   localparam logic [7:0]  FILL_BYTE = 8'hFF;
   localparam logic [9:0]  SECTOR_BYTES = 10'd512;
   localparam logic [5:0]  V2_OUTER_ROUNDS = 6'd50;

   // A count register holding zero behaves as one.
   function automatic logic [15:0] lim16(input logic [15:0] x);
      lim16 = (x == 16'd0) ? 16'd1 : x;
   endfunction

endpackage

// ===== rtl/sdi_if.sv =====
// Valid/ready channel interfaces for the SD card sequencer.
// Depends on nothing; the top level uses all three.
interface sdi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] sector_address;
   logic [7:0]  rx_byte;
   modport source (output valid, cmd, sector_address, rx_byte, input ready);
   modport sink   (input valid, cmd, sector_address, rx_byte, output ready);
endinterface

interface sdi_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       chip_select;
   logic [7:0] clock_divider;
   logic       data_valid;
   logic [7:0] data_byte;
   logic       data_last;
   logic       done_res;
   logic [1:0] status;
   logic       card_is_sdhc;
   modport source (output valid, tx_valid, tx_byte, chip_select, clock_divider,
                   data_valid, data_byte, data_last, done_res, status, card_is_sdhc,
                   input ready);
   modport sink   (input valid, tx_valid, tx_byte, chip_select, clock_divider,
                   data_valid, data_byte, data_last, done_res, status, card_is_sdhc,
                   output ready);
endinterface

interface sdi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sd_card_spi_init_and_read.sv =====
// Top level of the SD card SPI-mode init and single-block read sequencer.
// Depends on sdi_pkg and the channel interfaces in sdi_if.sv.
//
// Each request transfer is one SPI byte exchange event: start init, start a
// sector read, or hand over the byte the card returned. The block answers
// with one registered response transfer, naming the next byte to send,
// the chip select and the clock divider, and possibly a sector data byte or
// the completion status. A received byte while idle, or the unused command
// code, causes no response. One request is taken every cycle: the next state
// is a shallow function of the stored phase and counters, and the response
// register is parted from the request side so that a new request is taken
// whenever the response register is empty or is being drained in that cycle.
// Configuration writes are always accepted and take effect at once.
module sd_card_spi_init_and_read (
   input  logic       clock,
   input  logic       reset,
   sdi_req_if.sink    req,
   sdi_rsp_if.source  rsp,
   sdi_csr_if.sink    csr
);

   // Configuration registers.
   logic [7:0]  slow_div_ff, fast_div_ff, reset_att_ff;
   logic [9:0]  idle_fill_ff;
   logic [15:0] resp_poll_ff, v1_att_ff, v2_att_ff, token_poll_ff;

   // Sequencer state.
   sdi_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  byte_index_ff, byte_index_in;
   logic [15:0] resp_polls_ff, resp_polls_in;
   logic [15:0] inner_ff, inner_in;
   logic [5:0]  outer_ff, outer_in;
   logic [15:0] token_polls_ff, token_polls_in;
   logic        sdhc_ff, sdhc_in;
   logic        fast_ff, fast_in;
   logic [31:0] sector_ff, sector_in;
   logic [47:0] frame_ff, frame_in;

   // Response register.
   logic        rsp_valid_ff;
   logic        tx_valid_ff, tx_valid_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        cs_ff;
   logic [7:0]  div_ff;
   logic        data_valid_ff, data_valid_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic        data_last_ff, data_last_in;
   logic        done_ff, done_in;
   logic [1:0]  status_ff, status_in;
   logic        sdhc_out_ff;
   logic        produce;

   // Deferred actions, resolved after the main phase decode.
   logic        snd;
   logic [23:0] snd_op;
   logic [31:0] snd_arg;
   logic        inext, rfail, resp_chk;
   logic [31:0] arg_sh;
   logic        accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      resp_polls_in  = resp_polls_ff;
      inner_in       = inner_ff;
      outer_in       = outer_ff;
      token_polls_in = token_polls_ff;
      sdhc_in        = sdhc_ff;
      fast_in        = fast_ff;
      sector_in      = sector_ff;
      frame_in       = frame_ff;
      tx_valid_in    = 1'b0;
      tx_byte_in     = sdi_pkg::FILL_BYTE;
      data_valid_in  = 1'b0;
      data_byte_in   = 8'd0;
      data_last_in   = 1'b0;
      done_in        = 1'b0;
      status_in      = sdi_pkg::ST_OK;
      produce        = 1'b1;
      snd            = 1'b0;
      snd_op         = sdi_pkg::OP_CMD0;
      snd_arg        = 32'd0;
      inext          = 1'b0;
      rfail          = 1'b0;
      resp_chk       = 1'b0;
      arg_sh         = 32'd0;

      if (req.cmd == sdi_pkg::CMD_INIT) begin
         sdhc_in = 1'b1;
         fast_in = 1'b0;
         byte_index_in = 10'd0;
         phase_in = sdi_pkg::PH_SPIN_PRE;
         tx_valid_in = 1'b1;
      end else if (req.cmd == sdi_pkg::CMD_READ) begin
         sector_in = req.sector_address;
         phase_in = sdi_pkg::PH_RDPRE;
         tx_valid_in = 1'b1;
      end else if (req.cmd == sdi_pkg::CMD_BYTE && phase_ff != sdi_pkg::PH_IDLE) begin
         case (phase_ff)
            sdi_pkg::PH_SPIN_PRE, sdi_pkg::PH_SPIN_SDHC, sdi_pkg::PH_SPIN_V1,
            sdi_pkg::PH_SPIN_V2, sdi_pkg::PH_SPIN_V2R: begin
               byte_index_in = byte_index_ff + 10'd1;
               if (byte_index_in < sdi_pkg::lim16({6'd0, idle_fill_ff})) begin
                  tx_valid_in = 1'b1;
               end else begin
                  case (phase_ff)
                     sdi_pkg::PH_SPIN_PRE: begin
                        inner_in = 16'd0;
                        snd = 1'b1; snd_op = sdi_pkg::OP_CMD0;
                     end
                     sdi_pkg::PH_SPIN_SDHC: begin
                        snd = 1'b1; snd_op = sdi_pkg::OP_CMD8; snd_arg = sdi_pkg::ARG_CMD8;
                     end
                     sdi_pkg::PH_SPIN_V1: begin
                        inner_in = inner_ff + 16'd1;
                        snd = 1'b1;
                        if (inner_in >= sdi_pkg::lim16(v1_att_ff)) begin
                           snd_op = sdi_pkg::OP_CMD16; snd_arg = 32'd1;
                        end else begin
                           snd_op = sdi_pkg::OP_CMD1;
                        end
                     end
                     sdi_pkg::PH_SPIN_V2: begin
                        inner_in = 16'd0;
                        snd = 1'b1; snd_op = sdi_pkg::OP_CMD55;
                     end
                     default: inext = 1'b1;
                  endcase
               end
            end
            sdi_pkg::PH_CMD: begin
               if (byte_index_ff < 10'd5) begin
                  byte_index_in = byte_index_ff + 10'd1;
                  tx_valid_in = 1'b1;
                  case (byte_index_ff[2:0])
                     3'd0:    tx_byte_in = frame_ff[39:32];
                     3'd1:    tx_byte_in = frame_ff[31:24];
                     3'd2:    tx_byte_in = frame_ff[23:16];
                     3'd3:    tx_byte_in = frame_ff[15:8];
                     default: tx_byte_in = frame_ff[7:0];
                  endcase
               end else begin
                  resp_polls_in = 16'd1;
                  resp_chk = 1'b1;
               end
            end
            sdi_pkg::PH_RESP: begin
               resp_polls_in = resp_polls_ff + 16'd1;
               resp_chk = 1'b1;
            end
            sdi_pkg::PH_R7: begin
               if ((byte_index_ff == 10'd2 && req.rx_byte != 8'd1) ||
                   (byte_index_ff == 10'd3 && req.rx_byte != sdi_pkg::ECHO_PATTERN)) begin
                  sdhc_in = 1'b0; inner_in = 16'd0;
                  phase_in = sdi_pkg::PH_V1PRE; tx_valid_in = 1'b1;
               end else if (byte_index_ff == 10'd3) begin
                  phase_in = sdi_pkg::PH_TAIL8; tx_valid_in = 1'b1;
               end else begin
                  byte_index_in = byte_index_ff + 10'd1; tx_valid_in = 1'b1;
               end
            end
            sdi_pkg::PH_TAIL8: begin
               outer_in = 6'd0; byte_index_in = 10'd0;
               phase_in = sdi_pkg::PH_SPIN_V2; tx_valid_in = 1'b1;
            end
            sdi_pkg::PH_V1PRE: begin
               snd = 1'b1; snd_op = sdi_pkg::OP_CMD1;
            end
            sdi_pkg::PH_TAIL1: begin
               snd = 1'b1; snd_op = sdi_pkg::OP_CMD16; snd_arg = 32'd1;
            end
            sdi_pkg::PH_TAIL55: begin
               snd = 1'b1; snd_op = sdi_pkg::OP_ACMD41; snd_arg = sdi_pkg::ARG_ACMD41;
            end
            sdi_pkg::PH_TAIL41: begin
               snd = 1'b1; snd_op = sdi_pkg::OP_CMD58;
            end
            sdi_pkg::PH_OCR: begin
               if (byte_index_ff == 10'd0) sdhc_in = req.rx_byte[6];
               if (byte_index_ff < 10'd4) begin
                  byte_index_in = byte_index_ff + 10'd1; tx_valid_in = 1'b1;
               end else begin
                  snd = 1'b1; snd_op = sdi_pkg::OP_CMD16; snd_arg = 32'd1;
               end
            end
            sdi_pkg::PH_TAIL16: begin
               fast_in = 1'b1;
               phase_in = sdi_pkg::PH_IDLE; done_in = 1'b1;
            end
            sdi_pkg::PH_RDPRE: begin
               snd = 1'b1; snd_op = sdi_pkg::OP_CMD17; snd_arg = sector_ff;
            end
            sdi_pkg::PH_TOKEN: begin
               token_polls_in = token_polls_ff + 16'd1;
               if (req.rx_byte == sdi_pkg::TOKEN_START) begin
                  byte_index_in = 10'd0; phase_in = sdi_pkg::PH_DATA; tx_valid_in = 1'b1;
               end else if (token_polls_in >= sdi_pkg::lim16(token_poll_ff)) begin
                  phase_in = sdi_pkg::PH_IDLE; done_in = 1'b1;
                  status_in = sdi_pkg::ST_TOKEN_TIMEOUT;
               end else begin
                  tx_valid_in = 1'b1;
               end
            end
            sdi_pkg::PH_DATA: begin
               data_valid_in = 1'b1;
               data_byte_in = req.rx_byte;
               byte_index_in = byte_index_ff + 10'd1;
               tx_valid_in = 1'b1;
               if (byte_index_in >= sdi_pkg::SECTOR_BYTES) begin
                  data_last_in = 1'b1; byte_index_in = 10'd0; phase_in = sdi_pkg::PH_CRC;
               end
            end
            sdi_pkg::PH_CRC: begin
               if (byte_index_ff < 10'd1) begin
                  byte_index_in = byte_index_ff + 10'd1; tx_valid_in = 1'b1;
               end else begin
                  phase_in = sdi_pkg::PH_IDLE; done_in = 1'b1;
               end
            end
            default: phase_in = sdi_pkg::PH_IDLE;
         endcase
      end else begin
         produce = 1'b0;
      end

      // A response is the first byte that is not all ones, or the last one
      // read once the poll limit is reached.
      if (resp_chk) begin
         if (req.rx_byte != sdi_pkg::FILL_BYTE ||
             resp_polls_in >= sdi_pkg::lim16(resp_poll_ff)) begin
            case (frame_ff[45:40])
               sdi_pkg::IDX_CMD0: begin
                  if (req.rx_byte == 8'd1) begin
                     byte_index_in = 10'd0; phase_in = sdi_pkg::PH_SPIN_SDHC;
                     tx_valid_in = 1'b1;
                  end else begin
                     inner_in = inner_ff + 16'd1;
                     if (inner_in >= sdi_pkg::lim16({8'd0, reset_att_ff})) begin
                        phase_in = sdi_pkg::PH_IDLE; done_in = 1'b1;
                        status_in = sdi_pkg::ST_RESET_FAIL;
                     end else begin
                        snd = 1'b1; snd_op = sdi_pkg::OP_CMD0;
                     end
                  end
               end
               sdi_pkg::IDX_CMD8: begin
                  tx_valid_in = 1'b1;
                  if (req.rx_byte != 8'd1) begin
                     sdhc_in = 1'b0; inner_in = 16'd0; phase_in = sdi_pkg::PH_V1PRE;
                  end else begin
                     byte_index_in = 10'd0; phase_in = sdi_pkg::PH_R7;
                  end
               end
               sdi_pkg::IDX_CMD1: begin
                  tx_valid_in = 1'b1;
                  if (req.rx_byte == 8'd0) begin
                     phase_in = sdi_pkg::PH_TAIL1;
                  end else begin
                     byte_index_in = 10'd0; phase_in = sdi_pkg::PH_SPIN_V1;
                  end
               end
               sdi_pkg::IDX_CMD55: begin
                  if (req.rx_byte == 8'd1) begin
                     phase_in = sdi_pkg::PH_TAIL55; tx_valid_in = 1'b1;
                  end else begin
                     inext = 1'b1;
                  end
               end
               sdi_pkg::IDX_CMD41: begin
                  tx_valid_in = 1'b1;
                  if (req.rx_byte == 8'd0) begin
                     phase_in = sdi_pkg::PH_TAIL41;
                  end else begin
                     byte_index_in = 10'd0; phase_in = sdi_pkg::PH_SPIN_V2R;
                  end
               end
               sdi_pkg::IDX_CMD58: begin
                  if (req.rx_byte == 8'd0) begin
                     byte_index_in = 10'd0; phase_in = sdi_pkg::PH_OCR; tx_valid_in = 1'b1;
                  end else begin
                     rfail = 1'b1;
                  end
               end
               sdi_pkg::IDX_CMD16: begin
                  phase_in = sdi_pkg::PH_TAIL16; tx_valid_in = 1'b1;
               end
               sdi_pkg::IDX_CMD17: begin
                  if (req.rx_byte == 8'd0) begin
                     token_polls_in = 16'd0; phase_in = sdi_pkg::PH_TOKEN;
                     tx_valid_in = 1'b1;
                  end else begin
                     phase_in = sdi_pkg::PH_IDLE; done_in = 1'b1;
                     status_in = sdi_pkg::ST_READ_REJECT;
                  end
               end
               default: phase_in = sdi_pkg::PH_IDLE;
            endcase
         end else begin
            phase_in = sdi_pkg::PH_RESP; tx_valid_in = 1'b1;
         end
      end

      // Next CMD55 attempt inside a V2 round, or the end of that round.
      if (inext) begin
         inner_in = inner_ff + 16'd1;
         if (inner_in >= sdi_pkg::lim16(v2_att_ff)) begin
            rfail = 1'b1;
         end else begin
            snd = 1'b1; snd_op = sdi_pkg::OP_CMD55; snd_arg = 32'd0;
         end
      end

      // A failed V2 round starts another one or gives up on SDHC.
      if (rfail) begin
         outer_in = outer_ff + 6'd1;
         if (outer_in >= sdi_pkg::V2_OUTER_ROUNDS) begin
            sdhc_in = 1'b0;
            snd = 1'b1; snd_op = sdi_pkg::OP_CMD16; snd_arg = 32'd1;
         end else begin
            byte_index_in = 10'd0; phase_in = sdi_pkg::PH_SPIN_V2; tx_valid_in = 1'b1;
         end
      end

      // Build the command frame; byte addressing shifts the argument by 9.
      if (snd) begin
         arg_sh = sdhc_in ? snd_arg : {snd_arg[22:0], 9'd0};
         frame_in = {snd_op[7:0], arg_sh, snd_op[23:16]};
         byte_index_in = 10'd0;
         phase_in = sdi_pkg::PH_CMD;
         tx_valid_in = 1'b1;
         tx_byte_in = snd_op[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_div_ff   <= 8'd150;
         fast_div_ff   <= 8'd1;
         idle_fill_ff  <= 10'd200;
         resp_poll_ff  <= 16'd1000;
         reset_att_ff  <= 8'd50;
         v1_att_ff     <= 16'd200;
         v2_att_ff     <= 16'd20000;
         token_poll_ff <= 16'd50000;
      end else if (csr.valid) begin
         case (sdi_pkg::csr_type'(csr.index))
            sdi_pkg::CSR_SLOW_DIV:   slow_div_ff   <= csr.data[7:0];
            sdi_pkg::CSR_FAST_DIV:   fast_div_ff   <= csr.data[7:0];
            sdi_pkg::CSR_IDLE_FILL:  idle_fill_ff  <= csr.data[9:0];
            sdi_pkg::CSR_RESP_POLL:  resp_poll_ff  <= csr.data;
            sdi_pkg::CSR_RESET_ATT:  reset_att_ff  <= csr.data[7:0];
            sdi_pkg::CSR_V1_ATT:     v1_att_ff     <= csr.data;
            sdi_pkg::CSR_V2_ATT:     v2_att_ff     <= csr.data;
            sdi_pkg::CSR_TOKEN_POLL: token_poll_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sdi_pkg::PH_IDLE;
         byte_index_ff  <= 10'd0;
         resp_polls_ff  <= 16'd0;
         inner_ff       <= 16'd0;
         outer_ff       <= 6'd0;
         token_polls_ff <= 16'd0;
         sdhc_ff        <= 1'b1;
         fast_ff        <= 1'b0;
         sector_ff      <= 32'd0;
         frame_ff       <= 48'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         resp_polls_ff  <= resp_polls_in;
         inner_ff       <= inner_in;
         outer_ff       <= outer_in;
         token_polls_ff <= token_polls_in;
         sdhc_ff        <= sdhc_in;
         fast_ff        <= fast_in;
         sector_ff      <= sector_in;
         frame_ff       <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= produce;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tx_valid_ff   <= tx_valid_in;
         tx_byte_ff    <= tx_byte_in;
         cs_ff         <= tx_valid_in && (phase_in != sdi_pkg::PH_SPIN_PRE);
         div_ff        <= fast_in ? fast_div_ff : slow_div_ff;
         data_valid_ff <= data_valid_in;
         data_byte_ff  <= data_byte_in;
         data_last_ff  <= data_last_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
         sdhc_out_ff   <= sdhc_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.tx_valid      = tx_valid_ff;
   assign rsp.tx_byte       = tx_byte_ff;
   assign rsp.chip_select   = cs_ff;
   assign rsp.clock_divider = div_ff;
   assign rsp.data_valid    = data_valid_ff;
   assign rsp.data_byte     = data_byte_ff;
   assign rsp.data_last     = data_last_ff;
   assign rsp.done_res      = done_ff;
   assign rsp.status        = status_ff;
   assign rsp.card_is_sdhc  = sdhc_out_ff;

endmodule

// ===== rtl/sdi_checker.sv =====
// Port-level checker for the SD card sequencer, bound to the top level.
// Depends on sd_card_spi_init_and_read being elaborated.
module sdi_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_chip_select,
   input logic       rsp_data_valid,
   input logic       rsp_data_last,
   input logic       rsp_done_res
);

   // A stalled response holds its byte.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("stalled response changed");

   // Without an exchange request the card is deselected and fill is sent.
   a_idle_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> !rsp_chip_select && rsp_tx_byte == 8'hFF)
      else $error("idle response drives select or data");

   // A finished operation requests no further exchange.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_tx_valid && !rsp_data_valid)
      else $error("done response still requests exchange");

   // The last-byte mark only comes with a sector byte.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_last |-> rsp_data_valid && rsp_tx_valid)
      else $error("last mark without data");

endmodule

bind sd_card_spi_init_and_read sdi_checker u_sdi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_tx_valid    (rsp.tx_valid),
   .rsp_tx_byte     (rsp.tx_byte),
   .rsp_chip_select (rsp.chip_select),
   .rsp_data_valid  (rsp.data_valid),
   .rsp_data_last   (rsp.data_last),
   .rsp_done_res    (rsp.done_res)
);

// ===== tb/sd_card_spi_init_and_read_tb.sv =====
// Testbench for the SD card SPI-mode init and sector read sequencer.
// Needs sdi_pkg, the channel interfaces in sdi_if.sv and the top level.
`timescale 1ns / 100ps

module sd_card_spi_init_and_read_tb;
   import sdi_pkg::*;

   // One response transfer as the block presents it.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic [7:0] clock_divider;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       data_last;
      logic       done_res;
      logic [1:0] status;
      logic       card_is_sdhc;
   } exchange_t;

   logic clock;
   logic reset;

   sdi_req_if req_ch ();
   sdi_rsp_if rsp_ch ();
   sdi_csr_if csr_ch ();

   sd_card_spi_init_and_read uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Responses that the sequencer model has produced and that the block
   // still owes us, oldest first.
   exchange_t pending_exchanges[$];
   int        mismatches = 0;
   int        random_items = 0;
   bit        no_gaps = 0;      // when set, neither side inserts idle cycles
   int        hold_cycles = 0;  // long receiver hold-off, counted down below

   // Shadow copy of the configuration registers.
   logic [7:0]  slow_div, fast_div;
   logic [9:0]  fill_count;
   logic [15:0] resp_limit, cmd0_tries, v1_tries, v2_tries, token_limit;

   // Shadow copy of the sequencer state.
   phase_type   ph;
   logic [9:0]  bidx;
   logic [15:0] rpolls, inner, tpolls;
   logic [5:0]  outer;
   logic        sdhc, fastclk;
   logic [31:0] sector;
   logic [47:0] frame;

   // Outputs of the step being modeled.
   logic       o_txv, o_dv, o_last, o_done;
   logic [7:0] o_tx, o_data;
   logic [1:0] o_status;

   //------------------------------------------------------------------------
   // Sequencer model
   //------------------------------------------------------------------------

   // A count register that holds zero behaves as if it held one.
   function automatic logic [15:0] at_least_one(input logic [15:0] x);
      return (x == 16'd0) ? 16'd1 : x;
   endfunction

   function void emit(input phase_type p, input logic [7:0] b);
      ph    = p;
      o_txv = 1'b1;
      o_tx  = b;
   endfunction

   function void finish_op(input status_type st);
      ph       = PH_IDLE;
      o_txv    = 1'b0;
      o_tx     = FILL_BYTE;
      o_done   = 1'b1;
      o_status = st;
   endfunction

   function void spin(input phase_type p);
      bidx = '0;
      emit(p, FILL_BYTE);
   endfunction

   function automatic logic [7:0] frame_byte(input logic [9:0] k);
      int sh;
      sh = 40 - 8 * (k % 6);
      return frame[sh +: 8];
   endfunction

   // Byte-addressed cards take the block number shifted into a byte address.
   function void send_cmd(input logic [23:0] op, input logic [31:0] arg);
      if (!sdhc) arg = arg << 9;
      frame = {op[7:0], arg, op[23:16]};
      bidx  = '0;
      emit(PH_CMD, frame_byte(10'd0));
   endfunction

   function void cmd16_begin();
      send_cmd(OP_CMD16, 32'd1);
   endfunction

   function void v1_begin();
      sdhc  = 1'b0;
      inner = '0;
      emit(PH_V1PRE, FILL_BYTE);
   endfunction

   function void v2_round_fail();
      outer = outer + 6'd1;
      if (outer >= V2_OUTER_ROUNDS) begin
         sdhc = 1'b0;
         cmd16_begin();
      end else begin
         spin(PH_SPIN_V2);
      end
   endfunction

   function void v2_inner_next();
      inner = inner + 16'd1;
      if (inner >= at_least_one(v2_tries)) v2_round_fail();
      else send_cmd(OP_CMD55, 32'd0);
   endfunction

   function void on_response(input logic [7:0] r);
      case (frame[45:40])
         IDX_CMD0: begin
            if (r == 8'd1) begin
               spin(PH_SPIN_SDHC);
            end else begin
               inner = inner + 16'd1;
               if (inner >= at_least_one({8'd0, cmd0_tries[7:0]}))
                  finish_op(ST_RESET_FAIL);
               else
                  send_cmd(OP_CMD0, 32'd0);
            end
         end
         IDX_CMD8: begin
            if (r != 8'd1) v1_begin();
            else begin bidx = '0; emit(PH_R7, FILL_BYTE); end
         end
         IDX_CMD1:  if (r == 8'd0) emit(PH_TAIL1, FILL_BYTE); else spin(PH_SPIN_V1);
         IDX_CMD55: if (r == 8'd1) emit(PH_TAIL55, FILL_BYTE); else v2_inner_next();
         IDX_CMD41: if (r == 8'd0) emit(PH_TAIL41, FILL_BYTE); else spin(PH_SPIN_V2R);
         IDX_CMD58: begin
            if (r == 8'd0) begin bidx = '0; emit(PH_OCR, FILL_BYTE); end
            else v2_round_fail();
         end
         IDX_CMD16: emit(PH_TAIL16, FILL_BYTE);
         IDX_CMD17: begin
            if (r == 8'd0) begin tpolls = '0; emit(PH_TOKEN, FILL_BYTE); end
            else finish_op(ST_READ_REJECT);
         end
         default: ph = PH_IDLE;
      endcase
   endfunction

   function void spin_next();
      bidx = bidx + 10'd1;
      if (bidx < at_least_one({6'd0, fill_count})) begin
         emit(ph, FILL_BYTE);
         return;
      end
      case (ph)
         PH_SPIN_PRE:  begin inner = '0; send_cmd(OP_CMD0, 32'd0); end
         PH_SPIN_SDHC: send_cmd(OP_CMD8, ARG_CMD8);
         PH_SPIN_V1: begin
            inner = inner + 16'd1;
            if (inner >= at_least_one(v1_tries)) cmd16_begin();
            else send_cmd(OP_CMD1, 32'd0);
         end
         PH_SPIN_V2:   begin inner = '0; send_cmd(OP_CMD55, 32'd0); end
         default:      v2_inner_next();
      endcase
   endfunction

   // A response is the first non-fill byte, or whatever came last once the
   // poll limit is used up.
   function void check_response(input logic [7:0] rx);
      if (rx != FILL_BYTE || rpolls >= at_least_one(resp_limit)) on_response(rx);
      else emit(PH_RESP, FILL_BYTE);
   endfunction

   function void on_byte(input logic [7:0] rx);
      case (ph)
         PH_SPIN_PRE, PH_SPIN_SDHC, PH_SPIN_V1, PH_SPIN_V2, PH_SPIN_V2R: spin_next();
         PH_CMD: begin
            if (bidx < 10'd5) begin
               bidx = bidx + 10'd1;
               emit(PH_CMD, frame_byte(bidx));
            end else begin
               rpolls = 16'd1;
               check_response(rx);
            end
         end
         PH_RESP: begin
            rpolls = rpolls + 16'd1;
            check_response(rx);
         end
         PH_R7: begin
            if ((bidx == 10'd2 && rx != 8'd1) || (bidx == 10'd3 && rx != ECHO_PATTERN))
               v1_begin();
            else if (bidx == 10'd3)
               emit(PH_TAIL8, FILL_BYTE);
            else begin
               bidx = bidx + 10'd1;
               emit(PH_R7, FILL_BYTE);
            end
         end
         PH_TAIL8:  begin outer = '0; spin(PH_SPIN_V2); end
         PH_V1PRE:  send_cmd(OP_CMD1, 32'd0);
         PH_TAIL1:  cmd16_begin();
         PH_TAIL55: send_cmd(OP_ACMD41, ARG_ACMD41);
         PH_TAIL41: send_cmd(OP_CMD58, 32'd0);
         PH_OCR: begin
            if (bidx == 10'd0) sdhc = rx[6];
            if (bidx < 10'd4) begin
               bidx = bidx + 10'd1;
               emit(PH_OCR, FILL_BYTE);
            end else begin
               cmd16_begin();
            end
         end
         PH_TAIL16: begin
            fastclk = 1'b1;
            finish_op(ST_OK);
         end
         PH_RDPRE: send_cmd(OP_CMD17, sector);
         PH_TOKEN: begin
            tpolls = tpolls + 16'd1;
            if (rx == TOKEN_START) begin bidx = '0; emit(PH_DATA, FILL_BYTE); end
            else if (tpolls >= at_least_one(token_limit)) finish_op(ST_TOKEN_TIMEOUT);
            else emit(PH_TOKEN, FILL_BYTE);
         end
         PH_DATA: begin
            o_dv   = 1'b1;
            o_data = rx;
            bidx   = bidx + 10'd1;
            if (bidx >= SECTOR_BYTES) begin
               o_last = 1'b1;
               bidx   = '0;
               emit(PH_CRC, FILL_BYTE);
            end else begin
               emit(PH_DATA, FILL_BYTE);
            end
         end
         PH_CRC: begin
            if (bidx < 10'd1) begin bidx = bidx + 10'd1; emit(PH_CRC, FILL_BYTE); end
            else finish_op(ST_OK);
         end
         default: ph = PH_IDLE;
      endcase
   endfunction

   // Advances the model by one accepted request; returns 1 when the block
   // owes a response for it.
   function automatic bit advance_sequencer(input cmd_type c, input logic [31:0] addr,
                                            input logic [7:0] rx, output exchange_t r);
      o_txv = 1'b0; o_tx = FILL_BYTE; o_dv = 1'b0; o_data = 8'd0;
      o_last = 1'b0; o_done = 1'b0; o_status = ST_OK;
      r = '0;
      if (c == CMD_INIT) begin
         sdhc    = 1'b1;
         fastclk = 1'b0;
         spin(PH_SPIN_PRE);
      end else if (c == CMD_READ) begin
         sector = addr;
         emit(PH_RDPRE, FILL_BYTE);
      end else if (c == CMD_BYTE && ph != PH_IDLE) begin
         on_byte(rx);
      end else begin
         return 1'b0;
      end
      r.tx_valid      = o_txv;
      r.tx_byte       = o_tx;
      r.chip_select   = o_txv && (ph != PH_SPIN_PRE);
      r.clock_divider = fastclk ? fast_div : slow_div;
      r.data_valid    = o_dv;
      r.data_byte     = o_data;
      r.data_last     = o_last;
      r.done_res      = o_done;
      r.status        = o_status;
      r.card_is_sdhc  = sdhc;
      return 1'b1;
   endfunction

   //------------------------------------------------------------------------
   // Card emulation: picks the byte a plausible card would return next, so
   // that most sequences get through init and into a data transfer.
   //------------------------------------------------------------------------
   function automatic logic [7:0] answer_byte();
      int p;
      p = $urandom_range(0, 99);
      if (p < 25) return FILL_BYTE;
      case (frame[45:40])
         IDX_CMD0:  return (p < 85) ? 8'd1 : 8'($urandom);
         IDX_CMD8:  return (p < 80) ? 8'd1 : 8'h05;
         IDX_CMD1:  return (p < 60) ? 8'd0 : 8'd1;
         IDX_CMD55: return (p < 90) ? 8'd1 : 8'($urandom);
         IDX_CMD41: return (p < 60) ? 8'd0 : 8'd1;
         IDX_CMD58: return (p < 90) ? 8'd0 : 8'($urandom);
         IDX_CMD17: return (p < 85) ? 8'd0 : 8'($urandom);
         default:   return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] card_byte();
      int p;
      p = $urandom_range(0, 99);
      if (p < 6) return 8'($urandom);   // line noise
      case (ph)
         PH_CMD:   return (bidx < 10'd5) ? 8'($urandom) : answer_byte();
         PH_RESP:  return answer_byte();
         PH_R7: begin
            if (bidx == 10'd2) return (p < 85) ? 8'd1 : 8'($urandom);
            if (bidx == 10'd3) return (p < 85) ? ECHO_PATTERN : 8'($urandom);
            return 8'($urandom);
         end
         PH_TOKEN: return (p < 40) ? TOKEN_START : ((p < 80) ? FILL_BYTE : 8'($urandom));
         default:  return 8'($urandom);
      endcase
   endfunction

   //------------------------------------------------------------------------
   // Drivers
   //------------------------------------------------------------------------

   // Offers one request and waits for its transfer; the model is advanced at
   // the edge that accepts it. Valid stays high afterwards so that a request
   // with no gap follows without a bubble.
   task automatic send_item(input cmd_type c, input logic [31:0] addr, input logic [7:0] rx);
      int        gap;
      exchange_t r;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.cmd            <= c;
      req_ch.sector_address <= addr;
      req_ch.rx_byte        <= rx;
      do @(posedge clock); while (!req_ch.ready);
      if (advance_sequencer(c, addr, rx, r)) pending_exchanges.push_back(r);
   endtask

   // Lets the block drain: every owed response has arrived and the response
   // register has had time to empty.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_exchanges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_type idx, input logic [15:0] value);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_SLOW_DIV:   slow_div    = value[7:0];
         CSR_FAST_DIV:   fast_div    = value[7:0];
         CSR_IDLE_FILL:  fill_count  = value[9:0];
         CSR_RESP_POLL:  resp_limit  = value;
         CSR_RESET_ATT:  cmd0_tries  = {8'd0, value[7:0]};
         CSR_V1_ATT:     v1_tries    = value;
         CSR_V2_ATT:     v2_tries    = value;
         CSR_TOKEN_POLL: token_limit = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   // Starts an operation and feeds card bytes until it finishes, or until
   // max_bytes have gone by so that the next start abandons it.
   task automatic run_op(input cmd_type c, input logic [31:0] addr, input int max_bytes);
      int n;
      send_item(c, addr, 8'($urandom));
      n = 0;
      while (ph != PH_IDLE && n < max_bytes) begin
         send_item(CMD_BYTE, $urandom, card_byte());
         n++;
      end
   endtask

   task automatic small_config();
      csr_write(CSR_SLOW_DIV, 16'($urandom));
      csr_write(CSR_FAST_DIV, 16'($urandom));
      csr_write(CSR_IDLE_FILL, 16'($urandom_range(0, 4)));
      csr_write(CSR_RESP_POLL, 16'($urandom_range(0, 4)));
      csr_write(CSR_RESET_ATT, 16'($urandom_range(0, 4)));
      csr_write(CSR_V1_ATT, 16'($urandom_range(0, 4)));
      csr_write(CSR_V2_ATT, 16'($urandom_range(0, 4)));
      csr_write(CSR_TOKEN_POLL, 16'($urandom_range(0, 6)));
   endtask

   //------------------------------------------------------------------------
   // Response side: random ready gaps, plus a long hold-off on request.
   //------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            while (hold_cycles > 0) begin
               @(posedge clock);
               hold_cycles--;
            end
         end
         gap = no_gaps ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Every response transfer is checked against the oldest owed response.
   always @(posedge clock) begin
      exchange_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_exchanges.size() == 0) begin
            $error("response transfer with nothing expected");
            mismatches++;
         end else begin
            e = pending_exchanges.pop_front();
            if (rsp_ch.tx_valid !== e.tx_valid) begin
               $error("tx_valid expected %0h actual %0h", e.tx_valid, rsp_ch.tx_valid);
               mismatches++;
            end
            if (rsp_ch.tx_byte !== e.tx_byte) begin
               $error("tx_byte expected %0h actual %0h", e.tx_byte, rsp_ch.tx_byte);
               mismatches++;
            end
            if (rsp_ch.chip_select !== e.chip_select) begin
               $error("chip_select expected %0h actual %0h", e.chip_select,
                      rsp_ch.chip_select);
               mismatches++;
            end
            if (rsp_ch.clock_divider !== e.clock_divider) begin
               $error("clock_divider expected %0h actual %0h", e.clock_divider,
                      rsp_ch.clock_divider);
               mismatches++;
            end
            if (rsp_ch.data_valid !== e.data_valid) begin
               $error("data_valid expected %0h actual %0h", e.data_valid, rsp_ch.data_valid);
               mismatches++;
            end
            if (rsp_ch.data_byte !== e.data_byte) begin
               $error("data_byte expected %0h actual %0h", e.data_byte, rsp_ch.data_byte);
               mismatches++;
            end
            if (rsp_ch.data_last !== e.data_last) begin
               $error("data_last expected %0h actual %0h", e.data_last, rsp_ch.data_last);
               mismatches++;
            end
            if (rsp_ch.done_res !== e.done_res) begin
               $error("done_res expected %0h actual %0h", e.done_res, rsp_ch.done_res);
               mismatches++;
            end
            if (rsp_ch.status !== e.status) begin
               $error("status expected %0h actual %0h", e.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.card_is_sdhc !== e.card_is_sdhc) begin
               $error("card_is_sdhc expected %0h actual %0h", e.card_is_sdhc,
                      rsp_ch.card_is_sdhc);
               mismatches++;
            end
         end
      end
   end

   //------------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------------

   // Bytes while idle and the unused command code cause nothing. A read
   // before any init uses block addressing, with address extremes.
   task automatic test_idle_and_early_read();
      send_item(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF);
      send_item(CMD_NONE, 32'h0, 8'h00);
      run_op(CMD_READ, 32'h0000_0000, 2000);
      run_op(CMD_READ, 32'hFFFF_FFFF, 2000);
   endtask

   // Full init at reset settings, then a read at the highest address.
   task automatic test_default_init();
      run_op(CMD_INIT, $urandom, 3000);
      run_op(CMD_READ, 32'hFFFF_FFFF, 2000);
   endtask

   // Register extremes: the longest idle fill, zero counts acting as one,
   // dividers at both ends, the widest poll limits.
   task automatic test_register_extremes();
      csr_write(CSR_SLOW_DIV, 16'h00FF);
      csr_write(CSR_FAST_DIV, 16'h0000);
      csr_write(CSR_IDLE_FILL, 16'd1023);
      csr_write(CSR_RESET_ATT, 16'd0);
      csr_write(CSR_RESP_POLL, 16'hFFFF);
      csr_write(CSR_V1_ATT, 16'hFFFF);
      csr_write(CSR_V2_ATT, 16'hFFFF);
      csr_write(CSR_TOKEN_POLL, 16'hFFFF);
      // Card refuses CMD0 once, so the single allowed attempt fails.
      send_item(CMD_INIT, 32'h0, 8'h00);
      while (ph != PH_IDLE) begin
         if (ph == PH_CMD && bidx == 10'd5) send_item(CMD_BYTE, $urandom, 8'h00);
         else send_item(CMD_BYTE, $urandom, 8'($urandom));
      end
      csr_write(CSR_SLOW_DIV, 16'h0000);
      csr_write(CSR_FAST_DIV, 16'h00FF);
      csr_write(CSR_IDLE_FILL, 16'd0);
      csr_write(CSR_RESP_POLL, 16'd0);
      csr_write(CSR_RESET_ATT, 16'h00FF);
      csr_write(CSR_V1_ATT, 16'd0);
      csr_write(CSR_V2_ATT, 16'd0);
      csr_write(CSR_TOKEN_POLL, 16'd0);
      run_op(CMD_INIT, 32'h0, 3000);
      // Single token poll: a non-token byte times the read out.
      send_item(CMD_READ, 32'h1234_5678, 8'h00);
      while (ph != PH_IDLE) begin
         if (ph == PH_TOKEN) send_item(CMD_BYTE, 32'h0, 8'h00);
         else send_item(CMD_BYTE, 32'h0, (ph == PH_RESP || ph == PH_CMD) ? 8'h00 : 8'hFF);
      end
   endtask

   // A new start abandons whatever is running.
   task automatic test_abandon();
      small_config();
      run_op(CMD_INIT, 32'h0, 3);
      run_op(CMD_READ, $urandom, 4);
      run_op(CMD_INIT, 32'h0, 3000);
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so
   // the response register fills and the request side stalls; afterwards
   // the sender pauses until everything owed has arrived.
   task automatic test_pressure();
      no_gaps = 1;
      hold_cycles = 80;
      run_op(CMD_READ, $urandom, 40);
      wait_drained();
      run_op(CMD_BYTE, $urandom, 2000);
      no_gaps = 0;
   endtask

   // Mostly well-formed init and read sequences with random card content,
   // mixed with noise, aborted operations and fresh register settings.
   task automatic test_random_traffic();
      int p;
      int start_count;
      while (random_items < 700) begin
         start_count = pending_exchanges.size();
         p = $urandom_range(0, 99);
         if (p < 8) small_config();
         no_gaps = ($urandom_range(0, 5) == 0);
         p = $urandom_range(0, 99);
         if (p < 40) begin
            run_op(CMD_INIT, $urandom, (p < 5) ? $urandom_range(1, 20) : 3000);
         end else if (p < 85) begin
            run_op(CMD_READ, $urandom, (p < 48) ? $urandom_range(1, 20) : 2000);
         end else begin
            send_item(cmd_type'($urandom_range(0, 3)), $urandom, 8'($urandom));
         end
         random_items += 20;
      end
      no_gaps = 0;
   endtask

   //------------------------------------------------------------------------
   // Clock, reset and sequencing
   //------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("sd_card_spi_init_and_read verification failed");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.cmd            <= CMD_NONE;
      req_ch.sector_address <= '0;
      req_ch.rx_byte        <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= CSR_SLOW_DIV;
      csr_ch.data           <= '0;
      slow_div = 8'd150; fast_div = 8'd1; fill_count = 10'd200;
      resp_limit = 16'd1000; cmd0_tries = 16'd50; v1_tries = 16'd200;
      v2_tries = 16'd20000; token_limit = 16'd50000;
      ph = PH_IDLE; bidx = '0; rpolls = '0; inner = '0; outer = '0; tpolls = '0;
      sdhc = 1'b1; sector = '0; frame = '0; fastclk = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_early_read();
      test_default_init();
      test_register_extremes();
      test_abandon();
      test_pressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_exchanges.size() == 0) begin
         $display("sd_card_spi_init_and_read verification clean");
      end else begin
         $display("sd_card_spi_init_and_read verification failed");
      end
      $finish;
   end

endmodule
